/* design/dcdrtg_pkg.sv */
// Shared types and constants for the di-cluster delta-R threshold grid.
package dcdrtg_pkg;

  localparam int MAX_CLUSTERS = 12;
  localparam int GRID_STEPS   = 10;

  localparam int ENERGY_W = 9;
  localparam int ETA_W    = 8;
  localparam int PHI_W    = 8;
  localparam int LIMIT_W  = 17;
  localparam int STEP_W   = 6;
  localparam int DIST_W   = 17;
  localparam int PASS_W   = 55;

  // used cells of the triangular grid
  localparam int MASK_W = GRID_STEPS * (GRID_STEPS + 1) / 2;

  // (GRID_STEPS-1) * 63 stays below 1024 for any grid up to ten steps
  localparam int THR_W = 10;

  localparam int CNT_W  = $clog2(MAX_CLUSTERS + 1);
  localparam int ADDR_W = $clog2(MAX_CLUSTERS);

  localparam int IN_DATA_W  = ((ENERGY_W + ETA_W + PHI_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((PASS_W + 2 + 7) / 8) * 8;

  localparam int PHI_TURN = 144;
  localparam int PHI_HALF = 72;

  // configuration register indexes
  localparam logic REG_DIST_LIMIT = 1'b0;
  localparam logic REG_STEP       = 1'b1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(526);
  localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(2);

  typedef struct packed {
    logic [PHI_W-1:0]    phi;
    logic [ETA_W-1:0]    eta;
    logic [ENERGY_W-1:0] energy;
  } cluster_t;

  typedef struct packed {
    logic                valid;
    logic                hit;
    logic [ENERGY_W-1:0] lead_energy;
  } pair_res_t;

endpackage

/* design/dual_cluster_delta_r_threshold_grid.sv */
// Di-cluster delta-R trigger: one word per cluster, one pass mask word per event.
// Each accepted word is a cluster (tuser high) or an empty marker; tlast closes the
// event and yields one output word holding the 55-bit threshold grid mask, the
// enough-clusters flag and the overflow flag. Up to MAX_CLUSTERS clusters are kept
// in a small RAM. A new cluster is paired with every stored one through a single
// distance pipeline fed from the RAM's one read port, one stored cluster per cycle.
// The input is not ready while a word is being processed; a closing word also
// waits while an earlier result has not yet been taken.
module dual_cluster_delta_r_threshold_grid (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // energy[8:0], eta_pos[16:9], phi_pos[24:17], zero padding above
  input  logic [dcdrtg_pkg::IN_DATA_W-1:0]     s_tdata,
  // present
  input  logic                                 s_tuser,
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // pass_mask[54:0], enough_clusters[55], overflow[56], zero padding above
  output logic [dcdrtg_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                                 cfg_we,
  input  logic                                 cfg_idx,
  input  logic [dcdrtg_pkg::LIMIT_W-1:0]       cfg_wdata
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                          state;
  logic [dcdrtg_pkg::LIMIT_W-1:0]      dist_limit;
  logic [dcdrtg_pkg::STEP_W-1:0]       thr_step;
  logic [dcdrtg_pkg::CNT_W-1:0]        cluster_count;
  logic [dcdrtg_pkg::CNT_W-1:0]        pairs_n;
  logic [dcdrtg_pkg::ADDR_W-1:0]       scan_idx;
  logic [dcdrtg_pkg::PASS_W-1:0]       event_mask;
  logic                                overflow_seen;
  logic                                rd_valid;
  logic                                cur_last;
  dcdrtg_pkg::cluster_t                cur;
  dcdrtg_pkg::cluster_t                in_cluster;
  dcdrtg_pkg::cluster_t                rd_cluster;
  dcdrtg_pkg::pair_res_t               res;
  logic                                dist_busy;
  logic [dcdrtg_pkg::PASS_W-1:0]       grid_mask;
  logic                                out_valid;
  logic [dcdrtg_pkg::PASS_W+1:0]       out_data;

  logic accept;
  logic store_ok;
  logic rd_en;
  logic scan_end;
  logic out_load;
  logic enough;

  assign in_cluster.energy = s_tdata[dcdrtg_pkg::ENERGY_W-1:0];
  assign in_cluster.eta    = s_tdata[dcdrtg_pkg::ENERGY_W +: dcdrtg_pkg::ETA_W];
  assign in_cluster.phi    = s_tdata[dcdrtg_pkg::ENERGY_W + dcdrtg_pkg::ETA_W +:
                                     dcdrtg_pkg::PHI_W];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign store_ok = s_tuser && (cluster_count < dcdrtg_pkg::CNT_W'(dcdrtg_pkg::MAX_CLUSTERS));
  assign rd_en    = (state == ST_SCAN);
  assign scan_end = (dcdrtg_pkg::CNT_W'(scan_idx) == pairs_n - dcdrtg_pkg::CNT_W'(1));
  assign out_load = (state == ST_DONE) && cur_last && (!out_valid || m_tready);
  assign enough   = (cluster_count >= dcdrtg_pkg::CNT_W'(2));

  dcdrtg_ram #(
    .WIDTH ($bits(dcdrtg_pkg::cluster_t)),
    .DEPTH (dcdrtg_pkg::MAX_CLUSTERS)
  ) u_store (
    .clk   (clk),
    .we    (accept && store_ok),
    .waddr (cluster_count[dcdrtg_pkg::ADDR_W-1:0]),
    .wdata (in_cluster),
    .re    (rd_en),
    .raddr (scan_idx),
    .rdata (rd_cluster)
  );

  dcdrtg_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_valid),
    .stored   (rd_cluster),
    .fresh    (cur),
    .limit    (dist_limit),
    .res      (res),
    .busy     (dist_busy)
  );

  dcdrtg_grid u_grid (
    .lead_energy (res.lead_energy),
    .sub_energy  (cur.energy),
    .step        (thr_step),
    .marks       (grid_mask)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_limit <= dcdrtg_pkg::LIMIT_RESET;
      thr_step   <= dcdrtg_pkg::STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        dcdrtg_pkg::REG_DIST_LIMIT: dist_limit <= cfg_wdata;
        dcdrtg_pkg::REG_STEP:       thr_step   <= cfg_wdata[dcdrtg_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and event state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cluster_count <= '0;
      event_mask    <= '0;
      overflow_seen <= 1'b0;
      rd_valid      <= 1'b0;
      out_valid     <= 1'b0;
      pairs_n       <= '0;
      scan_idx      <= '0;
      cur_last      <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      if (res.valid && res.hit) begin
        event_mask <= event_mask | grid_mask;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cur_last <= s_tlast;
            pairs_n  <= cluster_count;
            scan_idx <= '0;
            if (store_ok) begin
              cluster_count <= cluster_count + dcdrtg_pkg::CNT_W'(1);
            end else if (s_tuser) begin
              overflow_seen <= 1'b1;
            end
            state <= (store_ok && cluster_count != '0) ? ST_SCAN : ST_DONE;
          end
        end
        ST_SCAN: begin
          scan_idx <= scan_idx + dcdrtg_pkg::ADDR_W'(1);
          if (scan_end) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_valid && !dist_busy) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!cur_last) begin
            state <= ST_IDLE;
          end else if (out_load) begin
            cluster_count <= '0;
            event_mask    <= '0;
            overflow_seen <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= in_cluster;
    end
    if (out_load) begin
      out_data <= {overflow_seen, enough, enough ? event_mask : dcdrtg_pkg::PASS_W'(0)};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = dcdrtg_pkg::OUT_DATA_W'(out_data);

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cluster_count <= dcdrtg_pkg::CNT_W'(dcdrtg_pkg::MAX_CLUSTERS))
    else $error("cluster count above capacity");

  a_scan_addr: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> dcdrtg_pkg::CNT_W'(scan_idx) < pairs_n)
    else $error("read of an entry not yet stored");

  a_res_in_scan: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("pair result outside the scan");

  a_mask_needs_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data[dcdrtg_pkg::PASS_W] |-> out_data[dcdrtg_pkg::PASS_W-1:0] == '0)
    else $error("pass mask set without two clusters");
`endif

endmodule

/* design/dcdrtg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dcdrtg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/dcdrtg_dist.sv */
// Pipelined pair distance unit: wrapped phi, squares, compare against the limit.
module dcdrtg_dist (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  dcdrtg_pkg::cluster_t               stored,
  input  dcdrtg_pkg::cluster_t               fresh,
  input  logic [dcdrtg_pkg::LIMIT_W-1:0]     limit,
  output dcdrtg_pkg::pair_res_t              res,
  output logic                               busy
);

  logic signed [dcdrtg_pkg::ETA_W:0]   de;
  logic [dcdrtg_pkg::ETA_W-1:0]        de_abs;
  logic [dcdrtg_pkg::PHI_W-1:0]        dp_raw;
  logic [dcdrtg_pkg::PHI_W-1:0]        dp_mod;
  logic [6:0]                          dp_fold;

  logic                                v1, v2;
  logic [dcdrtg_pkg::ETA_W-1:0]        s1_de;
  logic [6:0]                          s1_dp;
  logic [dcdrtg_pkg::ENERGY_W-1:0]     s1_e;
  logic [15:0]                         s2_de_sq;
  logic [12:0]                         s2_dp_sq;
  logic [dcdrtg_pkg::ENERGY_W-1:0]     s2_e;
  logic [dcdrtg_pkg::DIST_W-1:0]       d2;

  always_comb begin
    de = $signed({stored.eta[dcdrtg_pkg::ETA_W-1], stored.eta})
       - $signed({fresh.eta[dcdrtg_pkg::ETA_W-1], fresh.eta});
    de_abs = de[dcdrtg_pkg::ETA_W] ? dcdrtg_pkg::ETA_W'(-de) : de[dcdrtg_pkg::ETA_W-1:0];
    dp_raw = (stored.phi >= fresh.phi) ? stored.phi - fresh.phi : fresh.phi - stored.phi;
    // one turn off, then the shorter way round
    dp_mod = (dp_raw >= dcdrtg_pkg::PHI_W'(dcdrtg_pkg::PHI_TURN))
           ? dp_raw - dcdrtg_pkg::PHI_W'(dcdrtg_pkg::PHI_TURN) : dp_raw;
    dp_fold = (dp_mod > dcdrtg_pkg::PHI_W'(dcdrtg_pkg::PHI_HALF))
            ? 7'(dcdrtg_pkg::PHI_W'(dcdrtg_pkg::PHI_TURN) - dp_mod) : dp_mod[6:0];
  end

  assign d2 = dcdrtg_pkg::DIST_W'(s2_de_sq) + dcdrtg_pkg::DIST_W'(s2_dp_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      res.valid <= v2;
    end
    s1_de           <= de_abs;
    s1_dp           <= dp_fold;
    s1_e            <= stored.energy;
    s2_de_sq        <= s1_de * s1_de;
    s2_dp_sq        <= 13'(s1_dp * s1_dp);
    s2_e            <= s1_e;
    res.hit         <= d2 < limit;
    res.lead_energy <= s2_e;
  end

  assign busy = v1 | v2 | res.valid;

endmodule

/* design/dcdrtg_grid.sv */
// Threshold grid marks for one passing pair.
module dcdrtg_grid (
  input  logic [dcdrtg_pkg::ENERGY_W-1:0] lead_energy,
  input  logic [dcdrtg_pkg::ENERGY_W-1:0] sub_energy,
  input  logic [dcdrtg_pkg::STEP_W-1:0]   step,
  output logic [dcdrtg_pkg::PASS_W-1:0]   marks
);

  logic [dcdrtg_pkg::THR_W-1:0]      thr     [dcdrtg_pkg::GRID_STEPS];
  logic [dcdrtg_pkg::GRID_STEPS-1:0] lead_ok;
  logic [dcdrtg_pkg::GRID_STEPS-1:0] sub_ok;

  always_comb begin
    for (int l = 0; l < dcdrtg_pkg::GRID_STEPS; l++) begin
      thr[l]     = dcdrtg_pkg::THR_W'(l * int'(step));
      lead_ok[l] = dcdrtg_pkg::THR_W'(lead_energy) >= thr[l];
      sub_ok[l]  = dcdrtg_pkg::THR_W'(sub_energy) >= thr[l];
    end
  end

  // cell (L,S) sits at bit L*(L+1)/2+S
  always_comb begin
    marks = '0;
    for (int l = 0; l < dcdrtg_pkg::GRID_STEPS; l++) begin
      for (int s = 0; s < dcdrtg_pkg::GRID_STEPS; s++) begin
        if (s <= l) begin
          marks[l * (l + 1) / 2 + s] = lead_ok[l] & sub_ok[s];
        end
      end
    end
  end

endmodule

/* verif/dual_cluster_delta_r_threshold_grid_test.sv */
// Self-checking stream testbench for the di-cluster delta-R threshold grid.
module dual_cluster_delta_r_threshold_grid_test;
  import dcdrtg_pkg::*;

  // 1100 words with random gaps, stalls and one long hold-off stay far below this
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 600;
  localparam int IDLE_PCT      = 37;
  localparam int PHASE_WORDS   = 150;
  localparam int REPORT_LIMIT  = 10;

  typedef struct {
    logic [ENERGY_W-1:0]        energy;
    logic signed [ETA_W-1:0]    eta;
    logic [PHI_W-1:0]           phi;
    logic                       present;
    logic                       last;
  } cluster_word_t;

  typedef struct packed {
    logic              overflow;
    logic              enough;
    logic [PASS_W-1:0] mask;
  } grid_result_t;

  logic clk;
  logic rst = 1'b1;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic                  cfg_idx = REG_DIST_LIMIT;
  logic [LIMIT_W-1:0]    cfg_wdata = '0;

  cluster_word_t pending_words[$];
  grid_result_t  pending_results[$];

  // predictor state
  int                dist_limit_now = int'(LIMIT_RESET);
  int                step_now = int'(STEP_RESET);
  int                kept;
  int                kept_energy[MAX_CLUSTERS];
  int                kept_eta[MAX_CLUSTERS];
  int                kept_phi[MAX_CLUSTERS];
  logic [PASS_W-1:0] event_bits = '0;
  logic              spilled = 1'b0;

  logic quiet = 1'b0;
  logic hold_go = 1'b0;
  logic hold_on = 1'b0;

  int fault_count;
  int cycle_count;
  int words_taken;
  int clusters_taken;
  int events_seen;
  int paired_events;
  int spilled_events;
  int stalled_cycles;
  int settings_used;

  dual_cluster_delta_r_threshold_grid dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // shorter way round, after one reduction modulo a full turn
  function automatic int fold_phi(input int a, input int b);
    int d;
    d = (a >= b) ? a - b : b - a;
    if (d >= PHI_TURN) d -= PHI_TURN;
    if (d > PHI_HALF) d = PHI_TURN - d;
    return d;
  endfunction

  function automatic logic [PASS_W-1:0] cell_marks(input int lead, input int sub);
    logic [PASS_W-1:0] bits;
    bits = '0;
    for (int l = 0; l < GRID_STEPS; l++) begin
      if (lead >= l * step_now) begin
        for (int s = 0; s <= l; s++)
          if (sub >= s * step_now) bits[l * (l + 1) / 2 + s] = 1'b1;
      end
    end
    return bits;
  endfunction

  task automatic absorb_word(input cluster_word_t w);
    int de;
    int dp;
    grid_result_t r;
    if (w.present) begin
      clusters_taken++;
      if (kept < MAX_CLUSTERS) begin
        for (int i = 0; i < kept; i++) begin
          de = kept_eta[i] - int'(w.eta);
          dp = fold_phi(kept_phi[i], int'(w.phi));
          if (de * de + dp * dp < dist_limit_now)
            event_bits |= cell_marks(kept_energy[i], int'(w.energy));
        end
        kept_energy[kept] = int'(w.energy);
        kept_eta[kept]    = int'(w.eta);
        kept_phi[kept]    = int'(w.phi);
        kept++;
      end else begin
        spilled = 1'b1;
      end
    end
    if (w.last) begin
      r.mask     = (kept >= 2) ? event_bits : '0;
      r.enough   = (kept >= 2);
      r.overflow = spilled;
      pending_results.insert(pending_results.size(), r);
      kept       = 0;
      event_bits = '0;
      spilled    = 1'b0;
    end
  endtask

  task automatic note_fault(input string what, input logic [63:0] want, input logic [63:0] got);
    if (fault_count < REPORT_LIMIT)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
    fault_count++;
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] word);
    grid_result_t want;
    if (pending_results.size() == 0) begin
      note_fault("unexpected result word", '0, 64'(word));
    end else begin
      want = pending_results.pop_front();
      events_seen++;
      if (want.enough) paired_events++;
      if (want.overflow) spilled_events++;
      if (word[PASS_W-1:0] !== want.mask)
        note_fault("pass_mask", 64'(want.mask), 64'(word[PASS_W-1:0]));
      if (word[PASS_W] !== want.enough)
        note_fault("enough_clusters", 64'(want.enough), 64'(word[PASS_W]));
      if (word[PASS_W+1] !== want.overflow)
        note_fault("overflow", 64'(want.overflow), 64'(word[PASS_W+1]));
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
      s_tlast  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        absorb_word(pending_words.pop_front());
        words_taken++;
      end
      if (s_tvalid && !s_tready && hold_on) stalled_cycles++;
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= IN_DATA_W'({pending_words[0].phi, pending_words[0].eta,
                                  pending_words[0].energy});
          s_tuser  <= pending_words[0].present;
          s_tlast  <= pending_words[0].last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result(m_tdata);
      m_tready <= !hold_on && (quiet || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_word(input int energy, input int eta, input int phi,
                           input bit present, input bit last);
    cluster_word_t w;
    w.energy  = ENERGY_W'(energy);
    w.eta     = ETA_W'(eta);
    w.phi     = PHI_W'(phi);
    w.present = present;
    w.last    = last;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic write_reg(input logic idx, input int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= LIMIT_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DIST_LIMIT) dist_limit_now = value;
    else step_now = value;
  endtask

  // block is idle once nothing is queued, offered or owed, plus its pipeline depth
  task automatic drain();
    while (pending_words.size() != 0 || s_tvalid || pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_directed();
    push_word(0, 0, 0, 1'b0, 1'b1);            // lone empty marker closes an event
    push_word(511, 127, 143, 1'b1, 1'b1);      // single cluster, no pair
    push_word(511, 5, 70, 1'b1, 1'b0);         // same spot, full energies
    push_word(511, 5, 70, 1'b1, 1'b1);
    push_word(0, -128, 0, 1'b1, 1'b0);         // opposite corners, closed by marker
    push_word(511, 127, 143, 1'b1, 1'b0);
    push_word(0, 0, 0, 1'b0, 1'b1);
    push_word(20, 0, 0, 1'b1, 1'b0);           // phi wraps across zero
    push_word(3, 0, 143, 1'b1, 1'b1);
    push_word(255, -1, 255, 1'b1, 1'b0);       // phi beyond a full turn
    push_word(9, -1, 0, 1'b1, 1'b0);
    push_word(100, -3, 200, 1'b1, 1'b1);
    for (int k = 0; k < MAX_CLUSTERS + 1; k++) // one cluster past capacity
      push_word(k * 37, k - 6, k * 2, 1'b1, k == MAX_CLUSTERS);
  endtask

  // events of clustered positions so pairs pass often; some spread, empty and long ones
  task automatic queue_random_events(input int words);
    int made;
    int len;
    int spread;
    int base_eta;
    int base_phi;
    int eta;
    int phi;
    int energy;
    made = 0;
    while (made < words) begin
      len      = ($urandom_range(9) == 0) ? $urandom_range(16, 12) : $urandom_range(8, 1);
      spread   = ($urandom_range(3) == 0) ? 60 : 12;
      base_eta = $urandom_range(255) - 128;
      base_phi = $urandom_range(143);
      for (int k = 0; k < len; k++) begin
        energy = ($urandom_range(2) == 0) ? $urandom_range(511) : $urandom_range(40);
        eta = base_eta + $urandom_range(2 * spread) - spread;
        if (eta > 127) eta = 127;
        if (eta < -128) eta = -128;
        if ($urandom_range(15) == 0) phi = $urandom_range(255);
        else phi = (base_phi + $urandom_range(2 * spread) - spread + PHI_TURN) % PHI_TURN;
        push_word(energy, eta, phi, $urandom_range(99) >= 10, k == len - 1);
      end
      made += len;
    end
  endtask

  initial begin
    int limits[7];
    int steps[7];
    limits = '{526, 131071, 0, 1, 2000, 0, 0};
    steps  = '{2, 63, 1, 0, 5, 0, 0};
    limits[5] = $urandom_range(6000);
    steps[5]  = $urandom_range(63);
    limits[6] = $urandom_range(131071);
    steps[6]  = $urandom_range(63, 1);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    settings_used = 1;
    queue_directed();
    drain();

    for (int p = 0; p < 7; p++) begin
      write_reg(REG_DIST_LIMIT, limits[p]);
      write_reg(REG_STEP, steps[p]);
      settings_used++;
      quiet = (p == 1);
      if (p == 4) hold_go = 1'b1;
      queue_random_events(PHASE_WORDS);
      drain();
    end

    $display("%0d words (%0d clusters) over %0d register settings, %0d cycles",
             words_taken, clusters_taken, settings_used, cycle_count);
    $display("%0d events checked: %0d with a pair, %0d over capacity; %0d input stall cycles",
             events_seen, paired_events, spilled_events, stalled_cycles);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", fault_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
